// ===== rtl/kpec_pkg.sv =====
// ----------------------------------------------------------------------------
// kpec_pkg: key press event classifier shared definitions
// Word types, register map, event and key codes used by the classifier.
// ----------------------------------------------------------------------------
package kpec_pkg;

   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned DATA_W  = 32;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_REPEAT     = 2'd2;

   localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET   = 16'd5;
   localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 16'd500;
   localparam logic [LIMIT_W-1:0] REPEAT_RESET     = 16'd50;

   // event codes
   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_PRESS        = 3'd1;
   localparam logic [2:0] EV_RELEASE      = 3'd2;
   localparam logic [2:0] EV_REPEAT       = 3'd3;
   localparam logic [2:0] EV_LONG_RELEASE = 3'd4;

   // key codes
   localparam logic [2:0] KEY_NONE   = 3'd0;
   localparam logic [2:0] KEY_STOP   = 3'd1;
   localparam logic [2:0] KEY_REV    = 3'd2;
   localparam logic [2:0] KEY_FWD    = 3'd3;
   localparam logic [2:0] KEY_LOWER  = 3'd4;
   localparam logic [2:0] KEY_UP     = 3'd5;
   localparam logic [2:0] KEY_SELECT = 3'd6;
   localparam logic [2:0] KEY_FUNC   = 3'd7;

   typedef struct packed {
      logic [4:0] panel_keys;
      logic       enter_pin;
      logic       mode_pin;
   } req_word_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [2:0] key_code;
   } rsp_word_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] debounce_limit;
      logic [LIMIT_W-1:0] long_press_limit;
      logic [LIMIT_W-1:0] repeat_limit;
   } cfg_type;

endpackage

// ===== rtl/kpec_if.sv =====
// ----------------------------------------------------------------------------
// kpec_if: classifier channel interfaces
// Valid/ready channels for scan words in and event words out.
// ----------------------------------------------------------------------------
interface kpec_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] panel_keys;
   logic       enter_pin;
   logic       mode_pin;

   modport source (output valid, output panel_keys, output enter_pin, output mode_pin,
                   input ready);
   modport sink   (input valid, input panel_keys, input enter_pin, input mode_pin,
                   output ready);
endinterface

interface kpec_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [2:0] key_code;

   modport source (output valid, output event_kind, output key_code, input ready);
   modport sink   (input valid, input event_kind, input key_code, output ready);
endinterface

// ===== rtl/kpec_scan.sv =====
// ----------------------------------------------------------------------------
// kpec_scan: key encoder and debounce / long-press scanner
// Encodes the key lines and steps the scanner once per accepted word.
// ----------------------------------------------------------------------------
module kpec_scan
   import kpec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output rsp_word_type rsp_word
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HELD     = 2'd2,
      PH_LONG     = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [2:0]         held_ff, held_in;
   logic [LIMIT_W-1:0] count_ff, count_in;
   logic [2:0]         key;
   logic [2:0]         event_in;
   logic               changed;

   // fixed priority: stop, rev, fwd, down, up, enter, mode
   always_comb begin
      if (req_word.panel_keys[3])      key = KEY_STOP;
      else if (req_word.panel_keys[4]) key = KEY_REV;
      else if (req_word.panel_keys[2]) key = KEY_FWD;
      else if (req_word.panel_keys[1]) key = KEY_LOWER;
      else if (req_word.panel_keys[0]) key = KEY_UP;
      else if (!req_word.enter_pin)    key = KEY_SELECT;
      else if (!req_word.mode_pin)     key = KEY_FUNC;
      else                             key = KEY_NONE;
   end

   assign changed = (key == KEY_NONE) || (key != held_ff);

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      count_in = count_ff + 16'd1;
      event_in = EV_NONE;
      unique case (phase_ff)
         PH_IDLE: begin
            count_in = count_ff;
            if (key != KEY_NONE) begin
               held_in  = key;
               count_in = '0;
               phase_in = PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            if (changed) begin
               count_in = count_ff;
               phase_in = PH_IDLE;
            end else if (count_ff >= cfg.debounce_limit) begin
               count_in = '0;
               phase_in = PH_HELD;
               event_in = EV_PRESS;
            end
         end
         PH_HELD: begin
            if (changed) begin
               count_in = count_ff;
               phase_in = PH_IDLE;
               event_in = EV_RELEASE;
            end else if (count_ff > cfg.long_press_limit) begin
               count_in = '0;
               phase_in = PH_LONG;
            end
         end
         PH_LONG: begin
            if (changed) begin
               count_in = count_ff;
               phase_in = PH_IDLE;
               event_in = EV_LONG_RELEASE;
            end else if (count_ff > cfg.repeat_limit) begin
               count_in = '0;
               event_in = EV_REPEAT;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // key code names the held key; an idle-to-debounce step carries no event
   always_comb begin
      rsp_word.event_kind = event_in;
      rsp_word.key_code   = (event_in == EV_NONE) ? KEY_NONE : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= KEY_NONE;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/kpec_obuf.sv =====
// ----------------------------------------------------------------------------
// kpec_obuf: two-entry result buffer
// Output register plus skid stage so a word can be taken while one waits.
// ----------------------------------------------------------------------------
module kpec_obuf
   import kpec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         push_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   logic         main_valid_ff, skid_valid_ff;
   rsp_word_type main_ff, skid_ff;
   logic         pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_word   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            main_ff <= push_word;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_ff       <= push_word;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= push_word;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

// ===== rtl/key_press_event_classifier_top.sv =====
// ----------------------------------------------------------------------------
// key_press_event_classifier_top: key press event classifier
// Debounces panel keys and reports press, release and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one scan word per tick: five panel key lines (1 = pressed)
//   and the active-low enter and mode pins. Every accepted word yields
//   exactly one word on rsp: event_kind and key_code, both zero when
//   nothing happened.
//   The scanner step is combinational; its result is registered in the
//   output buffer. Throughput is one word per cycle while rsp takes results.
//   A two-entry output buffer lets req take one more word while a result
//   waits; req.ready drops only when both entries are full.
//   Limits are written over the APB port (0x0 debounce, 0x4 long press,
//   0x8 repeat, 16 bits each) only while the block is idle; this binds the
//   user, and the block leaves it unchecked. Reset clears the scanner to
//   idle, empties the buffer and loads the limits with 5, 500 and 50.
// ----------------------------------------------------------------------------
module key_press_event_classifier_top
   import kpec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   kpec_req_if.sink          req,
   kpec_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type      cfg_ff;
   req_word_type req_word;
   rsp_word_type scan_word, out_word;
   logic         accept;
   logic         csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit   <= DEBOUNCE_RESET;
         cfg_ff.long_press_limit <= LONG_PRESS_RESET;
         cfg_ff.repeat_limit     <= REPEAT_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_DEBOUNCE:   cfg_ff.debounce_limit   <= pwdata[LIMIT_W-1:0];
            REG_LONG_PRESS: cfg_ff.long_press_limit <= pwdata[LIMIT_W-1:0];
            REG_REPEAT:     cfg_ff.repeat_limit     <= pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_DEBOUNCE:   prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_ff.debounce_limit};
         REG_LONG_PRESS: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_ff.long_press_limit};
         REG_REPEAT:     prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_ff.repeat_limit};
         default:        prdata = '0;
      endcase
   end

   assign req_word.panel_keys = req.panel_keys;
   assign req_word.enter_pin  = req.enter_pin;
   assign req_word.mode_pin   = req.mode_pin;
   assign accept              = req.valid && req.ready;

   kpec_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .cfg      (cfg_ff),
      .rsp_word (scan_word)
   );

   kpec_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_word  (scan_word),
      .push_ready (req.ready),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_word   (out_word)
   );

   assign rsp.event_kind = out_word.event_kind;
   assign rsp.key_code   = out_word.key_code;

   // a word with no event never names a key
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.event_kind == EV_NONE)) |-> (rsp.key_code == KEY_NONE))
      else $error("key code set on a word with no event");

   // rsp is valid at the next edge after every accepted word
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp.valid)
      else $error("accepted word did not reach the output");

   // back-pressure on req only when a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("req stalled with an empty output");

   // event codes above long release are never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.event_kind <= EV_LONG_RELEASE))
      else $error("undefined event code on rsp");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: key press event classifier testbench
// Drives scan words into the classifier and predicts every event word it
// returns. Covers the reset limits, key priority, press, release, long press
// with repeats, top limit values, random key sequences under random idling
// on both channels, and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import kpec_pkg::*;

   localparam int unsigned HOLD_OFF_CYCLES = 64;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_DEBOUNCE, SCAN_HELD, SCAN_LONG} scan_phase_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   kpec_req_if req_ch();
   kpec_rsp_if rsp_ch();

   key_press_event_classifier_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // scanner shadow state
   scan_phase_type scan_phase;
   logic [2:0]     tracked_key;
   logic [15:0]    tick_count;
   cfg_type        limits;

   rsp_word_type expected_events [$];
   int unsigned  mismatches = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   logic         hold_off = 1'b0;
   event         hold_off_go;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAIL key_press_event_classifier_top");
      $finish;
   end

   function automatic req_word_type scan_word(logic [4:0] keys, logic enter, logic mode);
      req_word_type w;
      w.panel_keys = keys;
      w.enter_pin  = enter;
      w.mode_pin   = mode;
      return w;
   endfunction

   function automatic logic [2:0] key_of(req_word_type w);
      if (w.panel_keys[3]) return KEY_STOP;
      if (w.panel_keys[4]) return KEY_REV;
      if (w.panel_keys[2]) return KEY_FWD;
      if (w.panel_keys[1]) return KEY_LOWER;
      if (w.panel_keys[0]) return KEY_UP;
      if (!w.enter_pin) return KEY_SELECT;
      if (!w.mode_pin) return KEY_FUNC;
      return KEY_NONE;
   endfunction

   // one scanner step; updates the shadow state
   function automatic rsp_word_type classify_scan(req_word_type w);
      logic [2:0]   k;
      logic         moved;
      rsp_word_type r;
      k = key_of(w);
      moved = (k == KEY_NONE) || (k != tracked_key);
      r.event_kind = EV_NONE;
      case (scan_phase)
         SCAN_IDLE: begin
            if (k != KEY_NONE) begin
               tracked_key = k;
               tick_count  = '0;
               scan_phase  = SCAN_DEBOUNCE;
            end
         end
         SCAN_DEBOUNCE: begin
            if (moved) begin
               scan_phase = SCAN_IDLE;
            end else if (tick_count >= limits.debounce_limit) begin
               tick_count   = '0;
               scan_phase   = SCAN_HELD;
               r.event_kind = EV_PRESS;
            end else begin
               tick_count = tick_count + 16'd1;
            end
         end
         SCAN_HELD: begin
            if (moved) begin
               scan_phase   = SCAN_IDLE;
               r.event_kind = EV_RELEASE;
            end else if (tick_count > limits.long_press_limit) begin
               tick_count = '0;
               scan_phase = SCAN_LONG;
            end else begin
               tick_count = tick_count + 16'd1;
            end
         end
         default: begin
            if (moved) begin
               scan_phase   = SCAN_IDLE;
               r.event_kind = EV_LONG_RELEASE;
            end else if (tick_count > limits.repeat_limit) begin
               tick_count   = '0;
               r.event_kind = EV_REPEAT;
            end else begin
               tick_count = tick_count + 16'd1;
            end
         end
      endcase
      r.key_code = (r.event_kind == EV_NONE) ? KEY_NONE : tracked_key;
      return r;
   endfunction

   // random word that encodes to the wanted key
   function automatic req_word_type word_for(logic [2:0] k);
      req_word_type w;
      do begin
         w = req_word_type'(7'($urandom));
      end while (key_of(w) != k);
      return w;
   endfunction

   // receiver: random stalls plus the long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      forever begin
         @(hold_off_go);
         hold_off <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // prediction on accepted scan words, checking on accepted event words
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            expected_events.push_back(classify_scan(
               scan_word(req_ch.panel_keys, req_ch.enter_pin, req_ch.mode_pin)));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_events.size() == 0) begin
               $error("event word with nothing expected: event_kind %0d key_code %0d",
                      rsp_ch.event_kind, rsp_ch.key_code);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_ch.event_kind !== want.event_kind) begin
                  $error("event_kind expected %0d got %0d", want.event_kind,
                         rsp_ch.event_kind);
                  mismatches++;
               end
               if (rsp_ch.key_code !== want.key_code) begin
                  $error("key_code expected %0d got %0d", want.key_code, rsp_ch.key_code);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic send_scan(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid      <= 1'b0;
         req_ch.panel_keys <= 5'($urandom);
         req_ch.enter_pin  <= 1'($urandom);
         req_ch.mode_pin   <= 1'($urandom);
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.panel_keys <= w.panel_keys;
      req_ch.enter_pin  <= w.enter_pin;
      req_ch.mode_pin   <= w.mode_pin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic hold_key(input logic [2:0] k, input int unsigned ticks);
      repeat (ticks) send_scan(word_for(k));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // upper data bits are don't-care, so fill them with noise
   task automatic write_limit(input logic [1:0] idx, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_DEBOUNCE:   limits.debounce_limit   = value;
         REG_LONG_PRESS: limits.long_press_limit = value;
         default:        limits.repeat_limit     = value;
      endcase
   endtask

   task automatic configure_limits(input logic [15:0] deb, input logic [15:0] lng,
                                   input logic [15:0] rep);
      drain_results();
      write_limit(REG_DEBOUNCE, deb);
      write_limit(REG_LONG_PRESS, lng);
      write_limit(REG_REPEAT, rep);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(input int unsigned sender, input int unsigned receiver);
      send_idle_pct  = sender;
      recv_stall_pct = receiver;
   endtask

   // key holds of random length around the limits, with some noise between
   task automatic random_bursts(input int unsigned n_words);
      int unsigned sent;
      int unsigned len;
      int unsigned span;
      sent = 0;
      span = limits.debounce_limit + limits.long_press_limit + 4 * limits.repeat_limit + 12;
      while (sent < n_words) begin
         if ($urandom_range(99) < 15) begin
            len = $urandom_range(1, 6);
            repeat (len) send_scan(req_word_type'(7'($urandom)));
         end else begin
            len = $urandom_range(1, span);
            hold_key(3'($urandom_range(1, 7)), len);
            if ($urandom_range(1) == 0) begin
               send_scan(word_for(KEY_NONE));
               len++;
            end
         end
         sent += len;
      end
   endtask

   // default limits: press lands on the seventh tick
   task automatic test_reset_limits();
      hold_key(KEY_UP, 7);
      send_scan(word_for(KEY_NONE));
      drain_results();
   endtask

   // each key in priority order with all lower keys also down, then long press
   task automatic test_key_sweep();
      req_word_type sweep [7];
      sweep[0] = scan_word(5'b11111, 1'b0, 1'b0);
      sweep[1] = scan_word(5'b10111, 1'b0, 1'b0);
      sweep[2] = scan_word(5'b00111, 1'b0, 1'b0);
      sweep[3] = scan_word(5'b00011, 1'b0, 1'b0);
      sweep[4] = scan_word(5'b00001, 1'b0, 1'b0);
      sweep[5] = scan_word(5'b00000, 1'b0, 1'b0);
      sweep[6] = scan_word(5'b00000, 1'b1, 1'b0);
      configure_limits(16'd0, 16'd0, 16'd0);
      send_scan(sweep[0]);
      for (int i = 0; i < 7; i++) begin
         send_scan(sweep[i]);
         if (i < 6) begin
            send_scan(sweep[i + 1]);
            send_scan(sweep[i + 1]);
         end
      end
      repeat (4) send_scan(sweep[6]);
      send_scan(scan_word(5'b00000, 1'b1, 1'b1));
      drain_results();
   endtask

   // top limits: debounce never completes, then repeats never fire
   task automatic test_top_limits();
      set_idling(0, 0);
      configure_limits(16'hFFFF, 16'hFFFF, 16'd0);
      hold_key(KEY_STOP, 40);
      send_scan(word_for(KEY_NONE));
      configure_limits(16'd0, 16'd0, 16'hFFFF);
      hold_key(KEY_REV, 40);
      send_scan(word_for(KEY_NONE));
      drain_results();
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       set_idling(0, 0);
            1:       set_idling(59, 0);
            2:       set_idling(0, 59);
            default: set_idling(12, 12);
         endcase
         repeat (2) begin
            configure_limits(16'($urandom_range(0, 10)), 16'($urandom_range(0, 30)),
                             16'($urandom_range(0, 10)));
            random_bursts(180);
         end
      end
      drain_results();
   endtask

   // result side held off while words keep coming, then a full drain
   task automatic test_backpressure();
      set_idling(0, 0);
      configure_limits(16'd2, 16'd6, 16'd2);
      -> hold_off_go;
      random_bursts(40);
      drain_results();
      set_idling(12, 12);
      random_bursts(20);
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.panel_keys = '0;
      req_ch.enter_pin  = 1'b1;
      req_ch.mode_pin   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      scan_phase  = SCAN_IDLE;
      tracked_key = KEY_NONE;
      tick_count  = '0;
      limits.debounce_limit   = DEBOUNCE_RESET;
      limits.long_press_limit = LONG_PRESS_RESET;
      limits.repeat_limit     = REPEAT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_limits();
      test_key_sweep();
      test_top_limits();
      test_random_traffic();
      test_backpressure();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS key_press_event_classifier_top");
      end else begin
         $display("FAIL key_press_event_classifier_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/kpec_pkg.sv
rtl/kpec_if.sv
rtl/kpec_scan.sv
rtl/kpec_obuf.sv
rtl/key_press_event_classifier_top.sv
tb/tb_top.sv
